FILE: hdl/bed_pkg.sv
// bed_pkg: shared types, widths and codes of the button event detector
// used by every module of the block; no dependencies
`default_nettype none

package bed_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CFG_W       = 16;
	localparam int CMP_W       = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
	localparam int EV_SLOTS    = 4;

	localparam logic [1:0] STAGE_NORMAL = 2'd0;
	localparam logic [1:0] STAGE_PRESS  = 2'd1;
	localparam logic [1:0] STAGE_LONG   = 2'd2;

	localparam logic [2:0] EV_PRESSED   = 3'd0;
	localparam logic [2:0] EV_DOUBLE    = 3'd1;
	localparam logic [2:0] EV_TRIPLE    = 3'd2;
	localparam logic [2:0] EV_LONGPRESS = 3'd3;
	localparam logic [2:0] EV_REPEAT    = 3'd4;
	localparam logic [2:0] EV_SHORT_REL = 3'd5;
	localparam logic [2:0] EV_CLICK     = 3'd6;
	localparam logic [2:0] EV_LONG_REL  = 3'd7;

	localparam logic [1:0] REG_TICK_PERIOD = 2'd0;
	localparam logic [1:0] REG_LONG_PRESS  = 2'd1;
	localparam logic [1:0] REG_REPEAT      = 2'd2;
	localparam logic [1:0] REG_COMBO       = 2'd3;

	localparam logic [7:0]       RST_TICK_PERIOD = 8'd30;
	localparam logic [CFG_W-1:0] RST_LONG_PRESS  = 16'd1500;
	localparam logic [CFG_W-1:0] RST_REPEAT      = 16'd400;
	localparam logic [CFG_W-1:0] RST_COMBO       = 16'd300;

	localparam logic [11:0] ADC_BOTH_LO = 12'd500;
	localparam logic [11:0] ADC_BOTH_HI = 12'd700;
	localparam logic [11:0] ADC_B0_LO   = 12'd700;
	localparam logic [11:0] ADC_B0_HI   = 12'd900;
	localparam logic [11:0] ADC_B1_LO   = 12'd1600;
	localparam logic [11:0] ADC_B1_HI   = 12'd2000;

	typedef struct packed {
		logic [7:0]       tick_period_ms;
		logic [CFG_W-1:0] long_press_ms;
		logic [CFG_W-1:0] repeat_ms;
		logic [CFG_W-1:0] combo_ms;
	} cfg_t;

	// events of one button for one tick, at most two
	typedef struct packed {
		logic [1:0] n;
		logic [2:0] code0;
		logic [2:0] code1;
	} btn_ev_t;

	typedef struct packed {
		logic       button;
		logic [2:0] code;
	} ev_t;

endpackage

`default_nettype wire

FILE: hdl/bed_btn.sv
// bed_btn: debounce, click counter, timer and stage machine of one button
// depends on bed_pkg
`default_nettype none

module bed_btn (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic            level,
	input  wire bed_pkg::cfg_t   cfg,
	output bed_pkg::btn_ev_t     ev
);

	localparam int TW = bed_pkg::TIMER_WIDTH;
	localparam int CW = bed_pkg::CMP_W;
	localparam logic [TW-1:0] TMAX = {TW{1'b1}};

	logic [1:0]    stage_q, stage_d;
	logic          raw_q, raw_d;
	logic          stable_q, stable_d;
	logic [2:0]    click_q, click_d;
	logic [TW-1:0] elapsed_q, elapsed_d;

	logic [TW:0]   sum;
	logic [TW-1:0] e_sat;
	logic [CW-1:0] e_ext;
	logic [CW-1:0] long_ext, rep_ext, combo_ext;
	logic [CW:0]   combo_p1;
	logic [TW-1:0] combo_p1_sat;
	logic [2:0]    click_inc;

	always_comb begin
		sum      = {1'b0, elapsed_q} + {{(TW - 7){1'b0}}, cfg.tick_period_ms};
		e_sat    = sum[TW] ? TMAX : sum[TW-1:0];
		e_ext    = CW'(e_sat);
		long_ext  = CW'(cfg.long_press_ms);
		rep_ext   = CW'(cfg.repeat_ms);
		combo_ext = CW'(cfg.combo_ms);
		combo_p1  = {1'b0, combo_ext} + (CW + 1)'(1);
		combo_p1_sat = (combo_p1 > (CW + 1)'(TMAX)) ? TMAX : TW'(combo_p1);
		click_inc = click_q + 3'd1;
	end

	always_comb begin
		stage_d   = stage_q;
		raw_d     = raw_q;
		stable_d  = stable_q;
		click_d   = click_q;
		elapsed_d = e_sat;
		ev.n      = 2'd0;
		ev.code0  = bed_pkg::EV_PRESSED;
		ev.code1  = bed_pkg::EV_PRESSED;
		if (level != raw_q) begin
			raw_d = level;
		end else if (stable_q == raw_q && stage_q != bed_pkg::STAGE_PRESS &&
				stage_q != bed_pkg::STAGE_LONG && click_q == 3'd0) begin
			stable_d = stable_q;
		end else begin
			stable_d = raw_q;
			unique case (stage_q)
				bed_pkg::STAGE_PRESS: begin
					if (level) begin
						if (e_ext > long_ext) begin
							ev.n      = 2'd1;
							ev.code0  = bed_pkg::EV_LONGPRESS;
							elapsed_d = '0;
							stage_d   = bed_pkg::STAGE_LONG;
						end
					end else begin
						ev.n     = 2'd2;
						ev.code0 = bed_pkg::EV_SHORT_REL;
						ev.code1 = bed_pkg::EV_CLICK;
						if (click_q == 3'd0) click_d = 3'd1;
						stage_d = bed_pkg::STAGE_NORMAL;
					end
				end
				bed_pkg::STAGE_LONG: begin
					if (level) begin
						if (e_ext > rep_ext) begin
							ev.n      = 2'd1;
							ev.code0  = bed_pkg::EV_REPEAT;
							elapsed_d = '0;
						end
					end else begin
						ev.n      = 2'd1;
						ev.code0  = bed_pkg::EV_LONG_REL;
						click_d   = 3'd0;
						elapsed_d = combo_p1_sat;
						stage_d   = bed_pkg::STAGE_NORMAL;
					end
				end
				default: begin
					if (level) begin
						ev.n     = 2'd1;
						ev.code0 = bed_pkg::EV_PRESSED;
						if (e_ext < combo_ext && click_q != 3'd0 && click_q != 3'd7) begin
							click_d = click_inc;
							if (click_inc == 3'd2) begin
								ev.n     = 2'd2;
								ev.code1 = bed_pkg::EV_DOUBLE;
							end else if (click_inc == 3'd3) begin
								ev.n     = 2'd2;
								ev.code1 = bed_pkg::EV_TRIPLE;
							end
						end
						elapsed_d = '0;
						stage_d   = bed_pkg::STAGE_PRESS;
					end else begin
						if (e_ext > combo_ext && click_q != 3'd0) begin
							click_d   = 3'd0;
							elapsed_d = '0;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q   <= bed_pkg::STAGE_NORMAL;
			raw_q     <= 1'b0;
			stable_q  <= 1'b0;
			click_q   <= 3'd0;
			elapsed_q <= '0;
		end else if (step) begin
			stage_q   <= stage_d;
			raw_q     <= raw_d;
			stable_q  <= stable_d;
			click_q   <= click_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/bed_evbuf.sv
// bed_evbuf: result buffer holding the events of one tick, sent one per cycle while not stalled
// depends on bed_pkg
`default_nettype none

module bed_evbuf (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire bed_pkg::btn_ev_t ev0,
	input  wire bed_pkg::btn_ev_t ev1,
	output logic                  can_load,
	output logic                  evt_valid,
	input  wire logic             evt_stall,
	output logic                  button,
	output logic [2:0]            event_code,
	output logic                  last_event
);

	localparam int N = bed_pkg::EV_SLOTS;

	bed_pkg::ev_t ev_q [N];
	bed_pkg::ev_t slot [N];
	logic [2:0]   cnt_q;
	logic [2:0]   total;
	logic [2:0]   j;
	logic         xfer;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			j = 3'(i) - {1'b0, ev0.n};
			if (3'(i) < {1'b0, ev0.n}) begin
				slot[i].button = 1'b0;
				slot[i].code   = (i == 0) ? ev0.code0 : ev0.code1;
			end else begin
				slot[i].button = 1'b1;
				slot[i].code   = (j == 3'd0) ? ev1.code0 : ev1.code1;
			end
		end
		total = {1'b0, ev0.n} + {1'b0, ev1.n};
	end

	assign evt_valid  = cnt_q != 3'd0;
	assign xfer       = evt_valid && !evt_stall;
	assign can_load   = (cnt_q == 3'd0) || (cnt_q == 3'd1 && xfer);
	assign button     = ev_q[0].button;
	assign event_code = ev_q[0].code;
	assign last_event = cnt_q == 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= total;
		end else if (xfer) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ev_q <= slot;
		end else if (xfer) begin
			for (int i = 0; i < N - 1; i++) ev_q[i] <= ev_q[i + 1];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/button_event_detector.sv
// button_event_detector: two-button ladder decoder with click and long-press events
// depends on bed_pkg, bed_btn and bed_evbuf
//
// Usage: each adc_valid/adc_stall transfer is one scan tick carrying a 12-bit
// converter reading. The reading is held in an input register, decoded into a
// level per button and passed combinationally through each button's stage
// machine; the zero to four events of the tick go into a result buffer and
// leave on the evt_valid/evt_stall channel one per cycle while not stalled,
// first button first, with last_event marking the final event of the tick.
// A tick passes the input register, then the result buffer offers its first event.
// Throughput: one tick per cycle when ticks cause at most one event and the
// receiver does not stall; a tick with more events holds the next one until its
// final event leaves the one-event-per-cycle output buffer. A tick with no events
// still passes the input register. The next tick is taken while the buffer drains.
// When the receiver stalls, the buffer holds its head event and once the input
// register is full adc_stall rises. Reset clears all button state, empties the
// buffer and loads the default thresholds (30, 1500, 400, 300 ms). The user must
// write thresholds through the APB port only while the block is idle; not enforced.
`default_nettype none

module button_event_detector (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        adc_valid,
	output logic             adc_stall,
	input  wire logic [11:0] adc_sample,
	output logic             evt_valid,
	input  wire logic        evt_stall,
	output logic             button,
	output logic [2:0]       event_code,
	output logic             last_event,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	bed_pkg::cfg_t    cfg_q;
	bed_pkg::btn_ev_t ev0, ev1;
	logic [11:0]      adc_s1;
	logic             valid_s1;
	logic             can_load, consume;
	logic             lvl0, lvl1;
	logic             both;
	logic [1:0]       reg_idx;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period_ms <= bed_pkg::RST_TICK_PERIOD;
			cfg_q.long_press_ms  <= bed_pkg::RST_LONG_PRESS;
			cfg_q.repeat_ms      <= bed_pkg::RST_REPEAT;
			cfg_q.combo_ms       <= bed_pkg::RST_COMBO;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				bed_pkg::REG_TICK_PERIOD: cfg_q.tick_period_ms <= pwdata[7:0];
				bed_pkg::REG_LONG_PRESS:  cfg_q.long_press_ms  <= pwdata[15:0];
				bed_pkg::REG_REPEAT:      cfg_q.repeat_ms      <= pwdata[15:0];
				bed_pkg::REG_COMBO:       cfg_q.combo_ms       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			bed_pkg::REG_TICK_PERIOD: prdata = {24'd0, cfg_q.tick_period_ms};
			bed_pkg::REG_LONG_PRESS:  prdata = {16'd0, cfg_q.long_press_ms};
			bed_pkg::REG_REPEAT:      prdata = {16'd0, cfg_q.repeat_ms};
			bed_pkg::REG_COMBO:       prdata = {16'd0, cfg_q.combo_ms};
			default:                  prdata = 32'd0;
		endcase
	end

	// input register
	assign consume   = valid_s1 && can_load;
	assign adc_stall = valid_s1 && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adc_valid && !adc_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adc_valid && !adc_stall) adc_s1 <= adc_sample;
	end

	// ladder decode, bounds exclusive
	always_comb begin
		both = adc_s1 > bed_pkg::ADC_BOTH_LO && adc_s1 < bed_pkg::ADC_BOTH_HI;
		lvl0 = (adc_s1 > bed_pkg::ADC_B0_LO && adc_s1 < bed_pkg::ADC_B0_HI) || both;
		lvl1 = (adc_s1 > bed_pkg::ADC_B1_LO && adc_s1 < bed_pkg::ADC_B1_HI) || both;
	end

	bed_btn u_btn0 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.level  (lvl0),
		.cfg    (cfg_q),
		.ev     (ev0)
	);

	bed_btn u_btn1 (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.level  (lvl1),
		.cfg    (cfg_q),
		.ev     (ev1)
	);

	bed_evbuf u_evbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (consume),
		.ev0        (ev0),
		.ev1        (ev1),
		.can_load   (can_load),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.button     (button),
		.event_code (event_code),
		.last_event (last_event)
	);

endmodule

`default_nettype wire
